[src/fbh_pkg.sv]
// shared constants and types for the file name bucket hash block
`default_nettype none
package fbh_pkg;

   // field widths
   localparam int CHAR_W   = 8;
   localparam int HASH_W   = 31;
   localparam int BUCKET_W = 13;

   // position counter wraps after POS_MOD - 1
   localparam int POS_MOD  = 24;
   localparam int POS_W    = 5;

   // reset value of the bucket count register
   localparam logic [BUCKET_W-1:0] BUCKET_RESET = BUCKET_W'(201);

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // upper case ascii range that gets folded
   localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   // finished name hash handed from front to queue
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } push_type;

   // queue fill status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

[src/fbh_front.sv]
// front part: takes name bytes, folds case and accumulates the running hash
`default_nettype none
module fbh_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [fbh_pkg::CHAR_W-1:0]   req_char_code,
   input  wire                          req_last_char,
   input  fbh_pkg::queue_status_type    queue_status,
   output fbh_pkg::push_type            push
);
   import fbh_pkg::*;

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CHAR_W-1:0] folded;
   logic [HASH_W-1:0] term;
   logic [HASH_W-1:0] hash_next;
   logic              accept;

   // room in the queue is all a byte needs
   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;

   // fold upper case letters to lower case
   always_comb begin
      if (req_char_code inside {[UPPER_FIRST:UPPER_LAST]}) begin
         folded = req_char_code + CASE_OFFSET;
      end else begin
         folded = req_char_code;
      end
   end

   // shift by position and xor into the hash
   assign term      = HASH_W'(folded) << pos_ff;
   assign hash_next = hash_ff ^ term;

   // next hash and position
   always_comb begin
      hash_in = hash_ff;
      pos_in  = pos_ff;
      if (accept) begin
         if (req_last_char) begin
            hash_in = '0;
            pos_in  = '0;
         end else begin
            hash_in = hash_next;
            if (pos_ff == POS_W'(POS_MOD - 1)) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         pos_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         pos_ff  <= pos_in;
      end
   end

   // finished hash goes to the queue on the last byte
   assign push.valid = accept && req_last_char;
   assign push.hash  = hash_next;

endmodule
`default_nettype wire

[src/fbh_queue.sv]
// short queue of finished hashes between front and back
`default_nettype none
module fbh_queue #(
   parameter int DEPTH = fbh_pkg::QUEUE_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  fbh_pkg::push_type            push,
   output fbh_pkg::queue_status_type    status,
   output logic                         pop_valid,
   input  wire                          pop_ready,
   output logic [fbh_pkg::HASH_W-1:0]   pop_hash
);
   import fbh_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [HASH_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_valid    = !status.empty;
   assign pop_hash     = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !status.full;
   assign do_pop  = pop_valid && pop_ready;

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.hash;
      end
   end

endmodule
`default_nettype wire

[src/fbh_back.sv]
// back part: bit-serial modulo of a finished hash and the result register
`default_nettype none
module fbh_back (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           pop_valid,
   output logic                          pop_ready,
   input  wire  [fbh_pkg::HASH_W-1:0]    pop_hash,
   input  wire  [fbh_pkg::BUCKET_W-1:0]  bucket_count,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [fbh_pkg::BUCKET_W-1:0]  rsp_bucket_index
);
   import fbh_pkg::*;

   localparam int STEP_W = $clog2(HASH_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [HASH_W-1:0]   dividend_ff, dividend_in;
   logic [BUCKET_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_W-1:0] rsp_index_ff, rsp_index_in;
   logic [BUCKET_W:0]   trial;
   logic [BUCKET_W:0]   trial_diff;
   logic                out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = rsp_index_ff;
   assign pop_ready        = (state_ff == ST_IDLE);
   assign out_free         = !rsp_valid_ff || rsp_ready;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   assign trial      = {rem_ff, dividend_ff[HASH_W-1]};
   assign trial_diff = trial - {1'b0, bucket_count};

   always_comb begin
      state_in     = state_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               dividend_in = pop_hash;
               rem_in      = '0;
               step_in     = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (trial >= {1'b0, bucket_count}) begin
               rem_in = trial_diff[BUCKET_W-1:0];
            end else begin
               rem_in = trial[BUCKET_W-1:0];
            end
            dividend_in = {dividend_ff[HASH_W-2:0], 1'b0};
            step_in     = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(HASH_W - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // zero bucket count gives index zero
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = (bucket_count == '0) ? '0 : rem_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dividend_ff  <= dividend_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      rsp_index_ff <= rsp_index_in;
   end

endmodule
`default_nettype wire

[src/filename_bucket_hash.sv]
// top level of the file name bucket hash block
//
// A file name enters on the req_ channel one byte per word: req_char_code
// carries the byte, req_last_char marks the final byte of the name. Bytes
// A to Z are folded to lower case; each byte is shifted by its position modulo 24 and
// xored into a 31-bit hash. On the final byte the hash is queued and a
// bit-serial modulo unit reduces it by the bucket count.
// The rsp_ channel returns one word per name, rsp_bucket_index.
// The csr_ channel writes the bucket count; csr_ready is always high. The user
// makes writes only while the block is idle; the block does not enforce it.
// Throughput: a byte is taken every cycle while the hash queue has room.
// After the last byte is accepted the hash passes through the queue; the
// modulo unit loads it, makes 31 restoring steps and then loads the output
// register; it takes no new hash until then, so the modulo loop sets the name rate.
// Reset clears the hash, the position, the queue and the output valid flag,
// and sets the bucket count to 201.
// When the receiver stalls the result waits in the output register, the
// next modulo finishes and holds, and bytes keep arriving until the queue
// fills, after which req_ready drops.
`default_nettype none
module filename_bucket_hash #(
   parameter int QUEUE_DEPTH = fbh_pkg::QUEUE_DEPTH
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [fbh_pkg::CHAR_W-1:0]    req_char_code,
   input  wire                           req_last_char,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [fbh_pkg::BUCKET_W-1:0]  rsp_bucket_index,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire  [fbh_pkg::BUCKET_W-1:0]  csr_bucket_count
);
   import fbh_pkg::*;

   logic [BUCKET_W-1:0] bucket_count_ff;
   push_type            push;
   queue_status_type    queue_status;
   logic                pop_valid;
   logic                pop_ready;
   logic [HASH_W-1:0]   pop_hash;

   // bucket count register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_RESET;
      end else if (csr_valid && csr_ready) begin
         bucket_count_ff <= csr_bucket_count;
      end
   end

   // byte intake and hash accumulation
   fbh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .queue_status  (queue_status),
      .push          (push)
   );

   // finished hashes waiting for the modulo unit
   fbh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .status    (queue_status),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_hash  (pop_hash)
   );

   // modulo and result register
   fbh_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_hash         (pop_hash),
      .bucket_count     (bucket_count_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule
`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for the file name bucket hash block
`timescale 1ns / 1ps
module tb_top;
   import fbh_pkg::*;

   // tracks the running name hash and holds the bucket indexes still due
   class name_hash_tracker;
      logic [BUCKET_W-1:0] bucket_count;
      logic [HASH_W-1:0]   name_hash;
      logic [POS_W-1:0]    char_pos;
      logic [BUCKET_W-1:0] bucket_due_q [$];
      int                  failures;

      function new();
         bucket_count = BUCKET_RESET;
         name_hash    = '0;
         char_pos     = '0;
         failures     = 0;
      endfunction

      function void set_count(logic [BUCKET_W-1:0] value);
         bucket_count = value;
      endfunction

      // fold, shift by position, xor in; close the name on the last byte
      function void take_byte(logic [CHAR_W-1:0] code, logic last);
         logic [CHAR_W-1:0] folded;
         logic [HASH_W-1:0] term;
         folded = code;
         if (code >= UPPER_FIRST && code <= UPPER_LAST) begin
            folded = code + CASE_OFFSET;
         end
         term      = HASH_W'(folded) << char_pos;
         name_hash = name_hash ^ term;
         char_pos  = (char_pos == POS_W'(POS_MOD - 1)) ? '0 : char_pos + 1'b1;
         if (last) begin
            // a zero modulus gives index zero
            if (bucket_count == '0) begin
               bucket_due_q.push_back('0);
            end else begin
               bucket_due_q.push_back(BUCKET_W'(name_hash % bucket_count));
            end
            name_hash = '0;
            char_pos  = '0;
         end
      endfunction

      function void match_index(logic [BUCKET_W-1:0] actual);
         logic [BUCKET_W-1:0] want;
         if (bucket_due_q.size() == 0) begin
            $error("bucket_index: word with nothing due, actual %0d", actual);
            failures++;
         end else begin
            want = bucket_due_q.pop_front();
            if (actual !== want) begin
               $error("bucket_index: expected %0d actual %0d", want, actual);
               failures++;
            end
         end
      endfunction

      function int pending();
         return bucket_due_q.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic                req_last_char = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BUCKET_W-1:0] rsp_bucket_index;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [BUCKET_W-1:0] csr_bucket_count = '0;

   int                  tx_idle_pct = 14;
   int                  rx_idle_pct = 49;
   logic                hold_request = 1'b0;
   int                  bytes_sent = 0;
   name_hash_tracker    names = new();

   filename_bucket_hash uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bucket_index (rsp_bucket_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bucket_count (csr_bucket_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // give up long after the slowest correct run
   initial begin
      #20_000_000;
      $display("tb_top failed");
      $finish;
   end

   // offer one byte, idling at random first, and wait for the handshake
   task automatic send_byte(input logic [CHAR_W-1:0] code, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      req_last_char <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      names.take_byte(code, last);
      bytes_sent++;
   endtask

   // random name: mostly short, some past the position wrap
   task automatic send_name();
      int                len;
      int                pick;
      logic [CHAR_W-1:0] code;
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(12, 1);
      else if (pick < 90) len = $urandom_range(30, 13);
      else len = $urandom_range(60, 31);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 35) code = CHAR_W'($urandom_range(8'h5A, 8'h41));
         else if (pick < 60) code = CHAR_W'($urandom_range(8'h7A, 8'h61));
         else if (pick < 70) code = '0;
         else code = CHAR_W'($urandom_range(255));
         send_byte(code, i == len - 1);
      end
   endtask

   // stop sending and let every due word and the modulo pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      while (names.pending() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_count(input logic [BUCKET_W-1:0] value);
      csr_valid        <= 1'b1;
      csr_bucket_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      names.set_count(value);
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         0: begin
            tx_idle_pct = 14;
            rx_idle_pct = 49;
         end
         1: begin
            tx_idle_pct = 49;
            rx_idle_pct = 14;
         end
         default: begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
      endcase
   endtask

   // receiver: check accepted words, stall at random or for a long hold
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) begin
            names.match_index(rsp_bucket_index);
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 400;
            rsp_ready    <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // reset, directed names, then random names over several bucket counts
   initial begin
      logic [BUCKET_W-1:0] count_plan [0:7];
      int                  start;
      count_plan[0] = 13'd8191;
      count_plan[1] = 13'd1;
      count_plan[2] = 13'd0;
      count_plan[3] = 13'd2;
      count_plan[4] = 13'd8190;
      count_plan[5] = BUCKET_W'($urandom_range(8191, 3));
      count_plan[6] = BUCKET_W'($urandom_range(300, 3));
      count_plan[7] = BUCKET_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single byte names at the fold boundaries and the byte extremes
      send_byte(8'h41, 1'b1);
      send_byte(8'h5A, 1'b1);
      send_byte(8'h40, 1'b1);
      send_byte(8'h5B, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h7F, 1'b1);
      // mixed case name
      send_byte(8'h41, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h5A, 1'b1);
      // zero byte inside a name still moves the position
      send_byte(8'h61, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h62, 1'b1);
      settle();

      foreach (count_plan[p]) begin
         write_count(count_plan[p]);
         for (int mode = 0; mode < 3; mode++) begin
            set_idle(mode);
            start = bytes_sent;
            if (mode == 2 && (p == 1 || p == 5)) begin
               // burst of one-byte names into a long receiver hold
               hold_request = 1'b1;
               repeat (12) send_byte(CHAR_W'($urandom_range(255)), 1'b1);
            end
            while (bytes_sent - start < 46) send_name();
         end
         settle();
      end

      if (names.failures == 0 && names.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/fbh_pkg.sv
src/fbh_front.sv
src/fbh_queue.sv
src/fbh_back.sv
src/filename_bucket_hash.sv
bench/tb_top.sv
